[rtl/msf_pkg.sv]
// Shared types, constants and helpers for the MSF time-code keyer.
// Used by msf_frame_build, msf_slot_key and msf_time_code_keyer.
// No dependencies.
package msf_pkg;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int SLOTS_PER_SECOND   = 10;
    localparam int MARKER_SLOTS       = 5;

    localparam int SEC_W  = 6;
    localparam int SLOT_W = 4;

    localparam logic [SEC_W-1:0]  LAST_SECOND = SEC_W'(SECONDS_PER_MINUTE - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOTS_PER_SECOND - 1);

    // Input item function codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Upper bounds for the time fields
    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [3:0] MONTH_MAX   = 4'd12;
    localparam logic [4:0] DAY_MAX     = 5'd31;
    localparam logic [2:0] WEEKDAY_MAX = 3'd6;
    localparam logic [4:0] HOUR_MAX    = 5'd23;
    localparam logic [5:0] MINUTE_MAX  = 6'd59;

    typedef logic [SECONDS_PER_MINUTE-1:0] frame_t;

    typedef struct packed {
        logic [SEC_W-1:0]  second;
        logic [SLOT_W-1:0] slot;
    } slot_pos_t;

    // Binary to two-digit BCD for values below 100; tens by reciprocal multiply
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - 7'(tens) * 7'd10;
        return {tens, units[3:0]};
    endfunction

endpackage

[rtl/msf_frame_build.sv]
// Builds the A and B bit vectors of one MSF minute frame from the time fields.
// Depends on msf_pkg.
module msf_frame_build (
    input  logic [6:0]      year,
    input  logic [3:0]      month,
    input  logic [4:0]      day,
    input  logic [2:0]      weekday,
    input  logic [4:0]      hour,
    input  logic [5:0]      minute,
    input  logic            dst,
    output msf_pkg::frame_t frame_a,
    output msf_pkg::frame_t frame_b
);
    import msf_pkg::*;

    logic [7:0] year_bcd;
    logic [7:0] month_bcd;
    logic [7:0] day_bcd;
    logic [7:0] weekday_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] minute_bcd;

    always_comb begin
        year_bcd    = to_bcd((year > YEAR_MAX) ? YEAR_MAX : year);
        month_bcd   = to_bcd(7'((month > MONTH_MAX) ? MONTH_MAX : month));
        day_bcd     = to_bcd(7'((day > DAY_MAX) ? DAY_MAX : day));
        weekday_bcd = to_bcd(7'((weekday > WEEKDAY_MAX) ? WEEKDAY_MAX : weekday));
        hour_bcd    = to_bcd(7'((hour > HOUR_MAX) ? HOUR_MAX : hour));
        minute_bcd  = to_bcd(7'((minute > MINUTE_MAX) ? MINUTE_MAX : minute));
    end

    // Fields go out MSB first, so the lowest second carries the top code bit
    always_comb begin
        frame_a = '0;
        for (int k = 0; k < 8; k++) frame_a[17 + k] = year_bcd[7 - k];
        for (int k = 0; k < 5; k++) frame_a[25 + k] = month_bcd[4 - k];
        for (int k = 0; k < 6; k++) frame_a[30 + k] = day_bcd[5 - k];
        for (int k = 0; k < 3; k++) frame_a[36 + k] = weekday_bcd[2 - k];
        for (int k = 0; k < 6; k++) frame_a[39 + k] = hour_bcd[5 - k];
        for (int k = 0; k < 7; k++) frame_a[45 + k] = minute_bcd[6 - k];
        frame_a[58:53] = '1;
    end

    // Odd parity over each group, DST flag in 58
    always_comb begin
        frame_b     = '0;
        frame_b[54] = ~^frame_a[24:17];
        frame_b[55] = ~^frame_a[35:25];
        frame_b[56] = ~^frame_a[38:36];
        frame_b[57] = ~^frame_a[51:39];
        frame_b[58] = dst;
    end

endmodule

[rtl/msf_slot_key.sv]
// Carrier keying for one 100 ms slot, from the frame bits and the slot position.
// Depends on msf_pkg.
module msf_slot_key (
    input  msf_pkg::frame_t   frame_a,
    input  msf_pkg::frame_t   frame_b,
    input  msf_pkg::slot_pos_t pos,
    output logic              carrier_on
);
    import msf_pkg::*;

    logic a_bit;
    logic b_bit;

    assign a_bit = frame_a[pos.second];
    assign b_bit = frame_b[pos.second];

    always_comb begin
        if (pos.second == '0) begin
            carrier_on = (pos.slot >= SLOT_W'(MARKER_SLOTS));
        end else if (a_bit) begin
            carrier_on = (pos.slot >= (b_bit ? SLOT_W'(3) : SLOT_W'(2)));
        end else if (b_bit) begin
            // off, on, off, then on for the rest of the second
            carrier_on = (pos.slot == SLOT_W'(1)) || (pos.slot >= SLOT_W'(3));
        end else begin
            carrier_on = (pos.slot >= SLOT_W'(1));
        end
    end

endmodule

[rtl/msf_time_code_keyer.sv]
// MSF 60 kHz time-code keyer, top level.
// Depends on msf_pkg, msf_frame_build and msf_slot_key.
//
// Usage:
//   Input channel (s_*): one transfer per item. s_func = 1 loads the date and
//   time of the coming minute and arms a frame; s_func = 0 is a 100 ms tick
//   that sends one slot. Over-range time fields are clamped.
//   Result channel (m_*): exactly one result per input item, in order. A load
//   or a tick while idle returns carrier_on = idle_carrier with active low.
//   A tick while a frame runs returns the keying of that slot, its second and
//   slot index, and minute_done on slot 9 of second 59, after which the
//   block falls idle.
//   Config: cfg_wr_en writes idle_carrier from cfg_wr_data at once.
// Timing: the result is registered and valid in the cycle after the input transfer;
//   one item per cycle sustained while m_ready is high, set by the single result
//   register, which takes a new item in the same cycle as the previous result transfers.
// Reset: aresetn (synchronous, active low) clears the result valid flag, the
//   frame position and idle_carrier; the block comes up idle.
// Stall: while m_valid is high and m_ready low, s_ready is low and all state
//   but idle_carrier holds.
module msf_time_code_keyer (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [6:0] s_year,
    input  logic [3:0] s_month,
    input  logic [4:0] s_day,
    input  logic [2:0] s_weekday,
    input  logic [4:0] s_hour,
    input  logic [5:0] s_minute,
    input  logic       s_dst,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_carrier_on,
    output logic [5:0] m_second_index,
    output logic [3:0] m_slot_index,
    output logic       m_active,
    output logic       m_minute_done
);
    import msf_pkg::*;

    frame_t             frame_a_reg, frame_a_next;
    frame_t             frame_b_reg, frame_b_next;
    frame_t             built_a, built_b;
    slot_pos_t          pos_reg, pos_next;
    logic               running_reg, running_next;
    logic               idle_carrier_reg;
    logic               slot_carrier;
    logic               accept;

    logic               m_valid_reg, m_valid_next;
    logic               carrier_reg, carrier_next;
    logic [SEC_W-1:0]   second_reg, second_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               active_reg, active_next;
    logic               done_reg, done_next;

    msf_frame_build u_frame_build (
        .year    (s_year),
        .month   (s_month),
        .day     (s_day),
        .weekday (s_weekday),
        .hour    (s_hour),
        .minute  (s_minute),
        .dst     (s_dst),
        .frame_a (built_a),
        .frame_b (built_b)
    );

    msf_slot_key u_slot_key (
        .frame_a    (frame_a_reg),
        .frame_b    (frame_b_reg),
        .pos        (pos_reg),
        .carrier_on (slot_carrier)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Frame position and stored frame
    always_comb begin
        frame_a_next = frame_a_reg;
        frame_b_next = frame_b_reg;
        pos_next     = pos_reg;
        running_next = running_reg;
        if (accept) begin
            if (s_func == FUNC_LOAD) begin
                frame_a_next = built_a;
                frame_b_next = built_b;
                pos_next     = '0;
                running_next = 1'b1;
            end else if (running_reg) begin
                if (pos_reg.slot == LAST_SLOT) begin
                    pos_next.slot = '0;
                    if (pos_reg.second == LAST_SECOND) begin
                        pos_next.second = '0;
                        running_next    = 1'b0;
                    end else begin
                        pos_next.second = pos_reg.second + SEC_W'(1);
                    end
                end else begin
                    pos_next.slot = pos_reg.slot + SLOT_W'(1);
                end
            end
        end
    end

    // Result register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        carrier_next = carrier_reg;
        second_next  = second_reg;
        slot_next    = slot_reg;
        active_next  = active_reg;
        done_next    = done_reg;
        if (accept) begin
            m_valid_next = 1'b1;
            if ((s_func == FUNC_LOAD) || !running_reg) begin
                carrier_next = idle_carrier_reg;
                second_next  = '0;
                slot_next    = '0;
                active_next  = 1'b0;
                done_next    = 1'b0;
            end else begin
                carrier_next = slot_carrier;
                second_next  = pos_reg.second;
                slot_next    = pos_reg.slot;
                active_next  = 1'b1;
                done_next    = (pos_reg.second == LAST_SECOND) && (pos_reg.slot == LAST_SLOT);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg          <= '0;
            running_reg      <= 1'b0;
            idle_carrier_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            running_reg <= running_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                idle_carrier_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        frame_a_reg <= frame_a_next;
        frame_b_reg <= frame_b_next;
        carrier_reg <= carrier_next;
        second_reg  <= second_next;
        slot_reg    <= slot_next;
        active_reg  <= active_next;
        done_reg    <= done_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_carrier_on   = carrier_reg;
    assign m_second_index = second_reg;
    assign m_slot_index   = slot_reg;
    assign m_active       = active_reg;
    assign m_minute_done  = done_reg;

    // Position counters stay inside the minute
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg.slot <= LAST_SLOT) && (pos_reg.second <= LAST_SECOND))
        else $error("frame position out of range");

    // End of minute flagged only on the final slot of an active frame
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_minute_done) |->
            (m_active && m_second_index == LAST_SECOND && m_slot_index == LAST_SLOT))
        else $error("minute_done off the last slot");

    // Idle results carry a zero position
    a_idle_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_active) |-> (m_second_index == '0 && m_slot_index == '0))
        else $error("idle result with non-zero position");

    // Minute marker: carrier off for the first half of second zero
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_active && m_second_index == '0 &&
         m_slot_index < SLOT_W'(MARKER_SLOTS)) |-> !m_carrier_on)
        else $error("carrier on during minute marker");

    // Frame ends exactly after the transfer of the final slot
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_func == FUNC_TICK) && running_reg && pos_reg.second == LAST_SECOND &&
         pos_reg.slot == LAST_SLOT) |=> !running_reg)
        else $error("frame did not end after last slot");

endmodule

[tb/msf_time_code_keyer_test.sv]
// Self-checking testbench for msf_time_code_keyer: drives load and tick transfers,
// predicts every keyed slot and compares each result transfer field by field.
// Depends on msf_pkg and the msf_time_code_keyer RTL.
`timescale 1ns / 1ps

module msf_time_code_keyer_test;
    import msf_pkg::*;

    typedef struct packed {
        logic       func;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       dst;
    } keyer_item_t;

    typedef struct packed {
        logic              carrier_on;
        logic [SEC_W-1:0]  second_index;
        logic [SLOT_W-1:0] slot_index;
        logic              active;
        logic              minute_done;
    } slot_result_t;

    // Frame builder, slot keyer and queue of slots still owed by the block
    class keying_checker;
        frame_t            a_bits;
        frame_t            b_bits;
        logic [SEC_W-1:0]  sec;
        logic [SLOT_W-1:0] slot;
        bit                running;
        bit                idle_carrier;
        slot_result_t      expected_slots[$];
        int                errors;

        function new();
            a_bits       = '0;
            b_bits       = '0;
            sec          = '0;
            slot         = '0;
            running      = 1'b0;
            idle_carrier = 1'b0;
            errors       = 0;
        endfunction

        function int clamp(int v, int hi);
            return (v > hi) ? hi : v;
        endfunction

        // BCD of v, MSB at bit 'first', 'width' low bits of the code
        function frame_t bcd_field(int first, int width, int v);
            frame_t     f;
            logic [7:0] code;
            f    = '0;
            code = 8'(((v / 10) << 4) | (v % 10));
            for (int k = 0; k < width; k++) f[first + k] = code[width - 1 - k];
            return f;
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction

        function void note_transfer(keyer_item_t it);
            slot_result_t r;
            frame_t       a;
            r            = '0;
            r.carrier_on = idle_carrier;
            if (it.func == FUNC_LOAD) begin
                a = bcd_field(17, 8, clamp(it.year, YEAR_MAX))
                  | bcd_field(25, 5, clamp(it.month, MONTH_MAX))
                  | bcd_field(30, 6, clamp(it.day, DAY_MAX))
                  | bcd_field(36, 3, clamp(it.weekday, WEEKDAY_MAX))
                  | bcd_field(39, 6, clamp(it.hour, HOUR_MAX))
                  | bcd_field(45, 7, clamp(it.minute, MINUTE_MAX));
                // odd parity: B bit set when the covered A bits hold an even count
                b_bits     = '0;
                b_bits[54] = ~^a[24:17];
                b_bits[55] = ~^a[35:25];
                b_bits[56] = ~^a[38:36];
                b_bits[57] = ~^a[51:39];
                b_bits[58] = it.dst;
                a[58:53]   = '1;
                a_bits     = a;
                sec        = '0;
                slot       = '0;
                running    = 1'b1;
            end else if (running) begin
                r.second_index = sec;
                r.slot_index   = slot;
                r.active       = 1'b1;
                r.minute_done  = (sec == LAST_SECOND) && (slot == LAST_SLOT);
                if (sec == 0)
                    r.carrier_on = (slot >= MARKER_SLOTS);
                else if (a_bits[sec])
                    r.carrier_on = (slot >= (b_bits[sec] ? 3 : 2));
                else if (b_bits[sec])
                    r.carrier_on = (slot == 1) || (slot >= 3);
                else
                    r.carrier_on = (slot >= 1);
                if (slot == LAST_SLOT) begin
                    slot = '0;
                    if (sec == LAST_SECOND) begin
                        sec     = '0;
                        running = 1'b0;
                    end else begin
                        sec = sec + 1'b1;
                    end
                end else begin
                    slot = slot + 1'b1;
                end
            end
            expected_slots.push_back(r);
        endfunction

        function void check_transfer(slot_result_t got);
            slot_result_t want;
            if (expected_slots.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
                return;
            end
            want = expected_slots.pop_front();
            if (got.carrier_on !== want.carrier_on) begin
                $error("carrier_on: expected %0d, got %0d", want.carrier_on, got.carrier_on);
                errors++;
            end
            if (got.second_index !== want.second_index) begin
                $error("second_index: expected %0d, got %0d",
                       want.second_index, got.second_index);
                errors++;
            end
            if (got.slot_index !== want.slot_index) begin
                $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
                errors++;
            end
            if (got.active !== want.active) begin
                $error("active: expected %0d, got %0d", want.active, got.active);
                errors++;
            end
            if (got.minute_done !== want.minute_done) begin
                $error("minute_done: expected %0d, got %0d",
                       want.minute_done, got.minute_done);
                errors++;
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    logic       s_func;
    logic [6:0] s_year;
    logic [3:0] s_month;
    logic [4:0] s_day;
    logic [2:0] s_weekday;
    logic [4:0] s_hour;
    logic [5:0] s_minute;
    logic       s_dst;
    logic       m_valid;
    logic       m_ready;
    logic       m_carrier_on;
    logic [5:0] m_second_index;
    logic [3:0] m_slot_index;
    logic       m_active;
    logic       m_minute_done;

    bit            calm;
    keying_checker keying = new();

    msf_time_code_keyer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_year         (s_year),
        .s_month        (s_month),
        .s_day          (s_day),
        .s_weekday      (s_weekday),
        .s_hour         (s_hour),
        .s_minute       (s_minute),
        .s_dst          (s_dst),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_carrier_on   (m_carrier_on),
        .m_second_index (m_second_index),
        .m_slot_index   (m_slot_index),
        .m_active       (m_active),
        .m_minute_done  (m_minute_done)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Check the owed result first; a result never belongs to the input of the same edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            keying.check_transfer({m_carrier_on, m_second_index, m_slot_index,
                                   m_active, m_minute_done});
        if (aresetn && s_valid && s_ready)
            keying.note_transfer({s_func, s_year, s_month, s_day, s_weekday,
                                  s_hour, s_minute, s_dst});
    end

    // Receiver back-pressure in bursts
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Mostly in range, now and then any value the port width allows
    function automatic int field(int hi, int width);
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, (1 << width) - 1)
                                           : $urandom_range(0, hi);
    endfunction

    function automatic keyer_item_t load_item(int year, int month, int day, int weekday,
                                              int hour, int minute, bit dst);
        keyer_item_t it;
        it.func    = FUNC_LOAD;
        it.year    = 7'(year);
        it.month   = 4'(month);
        it.day     = 5'(day);
        it.weekday = 3'(weekday);
        it.hour    = 5'(hour);
        it.minute  = 6'(minute);
        it.dst     = dst;
        return it;
    endfunction

    function automatic keyer_item_t random_load();
        return load_item(field(99, 7), field(12, 4), field(31, 5), field(6, 3),
                         field(23, 5), field(59, 6), 1'($urandom_range(0, 1)));
    endfunction

    // Ticks carry random time fields too; the block should ignore them
    function automatic keyer_item_t tick_item();
        keyer_item_t it;
        it      = random_load();
        it.func = FUNC_TICK;
        return it;
    endfunction

    task automatic send_item(keyer_item_t it);
        @(negedge aclk);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        {s_func, s_year, s_month, s_day, s_weekday, s_hour, s_minute, s_dst} <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off until every owed result is in, then let the result stage drain
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (keying.pending() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_idle_carrier(bit level);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        keying.idle_carrier = level;
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid     = 1'b0;
        {s_func, s_year, s_month, s_day, s_weekday, s_hour, s_minute, s_dst} = '0;
        calm        = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_idle_carrier(1'b0);

        // directed: idle tick, clamped load, marker second, reload mid-frame, zero fields
        send_item(tick_item());
        send_item(load_item(127, 15, 31, 7, 31, 63, 1'b1));
        repeat (12) send_item(tick_item());
        send_item(load_item(99, 12, 31, 6, 23, 59, 1'b0));
        repeat (4) send_item(tick_item());
        send_item(load_item(0, 0, 0, 0, 0, 0, 1'b0));
        repeat (3) send_item(tick_item());
        settle();

        write_idle_carrier(1'b1);

        // noise: frequent reloads, frames never finish
        repeat (40) send_item(($urandom_range(0, 4) == 0) ? random_load() : tick_item());

        // one whole minute, then ticks past its end while idle
        send_item(random_load());
        repeat (SECONDS_PER_MINUTE * SLOTS_PER_SECOND + 10) send_item(tick_item());
        settle();

        write_idle_carrier(1'b0);
        calm = 1'b1;
        send_item(random_load());
        repeat (20) send_item(($urandom_range(0, 9) == 0) ? random_load() : tick_item());
        settle();

        if (keying.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
